// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, cond, prop)

`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- src/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, request codes and control types of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEFAULT = 8;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 3;
  localparam int DIM_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 32;

  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_B_COLS    = 2'd2;

  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctl_t;

endpackage

// ----- src/mme_store.sv -----
// ----------------------------------------------------------------------------
// mme_store
// Element store: one write port and one read port, registered read, per-entry valid
// bits so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module mme_store
  import mme_pkg::*;
#(
  parameter int DEPTH  = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ----- src/mme_mac.sv -----
// ----------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: registered product, wide accumulator and
// saturation of the sum to the signed 32-bit range.
// ----------------------------------------------------------------------------
module mme_mac
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic signed [VALUE_W-1:0]  a,
  input  logic signed [VALUE_W-1:0]  b,
  output logic                       busy,
  output logic signed [RESULT_W-1:0] result
);

  localparam int ACC_W = RESULT_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(32'sh8000_0000);

  logic signed [RESULT_W-1:0] prod;
  logic                       prod_vld;
  logic                       prod_first;
  logic signed [ACC_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld   <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_vld   <= ctl.vld;
      prod_first <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod <= a * b;
    end
    if (prod_vld) begin
      acc <= prod_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign busy = ctl.vld || prod_vld;

  always_comb begin
    if (acc > ACC_HI) begin
      result = 32'sh7FFF_FFFF;
    end else if (acc < ACC_LO) begin
      result = 32'sh8000_0000;
    end else begin
      result = acc[RESULT_W-1:0];
    end
  end

endmodule

// ----- src/matrix_multiply_engine_top.sv -----
// Write beat: after acceptance the engine enters the write-emit state and loads the result
// register once the output register is free, then returns to idle for the next request.
// Compute beat: each product element issues one pair of A and B reads per inner index through
// the read ports of the two stores, then drains the multiply-accumulate and waits for a free
// output register; a request streams one beat per product element and output stalls hold it.
// Reset (synchronous): dimensions return to 8 and both stores read as zero at once.
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// Stores A and B elements and streams the saturated Q16.16 product A times B.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6], zero pad
  output logic [0:0]  m_tuser,   // status[0]
  output logic        m_tlast
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WEMIT = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    if (r == '0) begin
      return DIM_W'(1);
    end else if (r > DIM_MAX) begin
      return DIM_MAX;
    end
    return r;
  endfunction

  logic [DIM_W-1:0] a_rows;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] b_cols;
  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_n;
  logic [DIM_W-1:0] dim_p;

  logic [2:0]       state;
  logic [IDX_W-1:0] idx_i;
  logic [IDX_W-1:0] idx_j;
  logic [IDX_W-1:0] idx_t;

  logic [POS_W-1:0] pend_row;
  logic [POS_W-1:0] pend_col;
  logic             pend_status;

  logic [POS_W-1:0]    in_row;
  logic [POS_W-1:0]    in_col;
  logic [VALUE_W-1:0]  in_value;
  logic [REQ_W-1:0]    in_req;
  logic                in_accept;
  logic [DIM_W-1:0]    lim_row;
  logic [DIM_W-1:0]    lim_col;
  logic                in_range;
  logic                a_wr_en;
  logic                b_wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   a_rd_addr;
  logic [ADDR_W-1:0]   b_rd_addr;
  logic [VALUE_W-1:0]  a_rd_data;
  logic [VALUE_W-1:0]  b_rd_data;

  mac_ctl_t                   mac_in;
  logic                       mac_busy;
  logic signed [RESULT_W-1:0] mac_result;
  logic                       last_t;
  logic                       last_j;
  logic                       last_i;

  logic                out_valid;
  logic                out_free;
  logic                out_load;
  logic [POS_W-1:0]    out_row;
  logic [POS_W-1:0]    out_col;
  logic [RESULT_W-1:0] out_value;
  logic                out_status;
  logic                out_last;
  logic [POS_W-1:0]    ld_row;
  logic [POS_W-1:0]    ld_col;
  logic [RESULT_W-1:0] ld_value;
  logic                ld_status;
  logic                ld_last;

  assign dim_m = eff_dim(a_rows);
  assign dim_n = eff_dim(inner_dim);
  assign dim_p = eff_dim(b_cols);

  assign in_row    = s_tdata[2:0];
  assign in_col    = s_tdata[5:3];
  assign in_value  = s_tdata[21:6];
  assign in_req    = s_tuser;
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      b_cols    <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_ROWS:    a_rows    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_B_COLS:    b_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lim_row  = (in_req == REQ_WRITE_A) ? dim_m : dim_n;
    lim_col  = (in_req == REQ_WRITE_A) ? dim_n : dim_p;
    in_range = (DIM_W'(in_row) < lim_row) && (DIM_W'(in_col) < lim_col);
    a_wr_en  = in_accept && (in_req == REQ_WRITE_A) && in_range;
    b_wr_en  = in_accept && (in_req == REQ_WRITE_B) && in_range;
    wr_addr  = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  end

  assign rd_en     = (state == ST_ISSUE);
  assign a_rd_addr = ADDR_W'(32'(idx_i) * MAX_DIM + 32'(idx_t));
  assign b_rd_addr = ADDR_W'(32'(idx_t) * MAX_DIM + 32'(idx_j));
  assign last_t    = (DIM_W'(idx_t) == dim_n - DIM_W'(1));
  assign last_j    = (DIM_W'(idx_j) == dim_p - DIM_W'(1));
  assign last_i    = (DIM_W'(idx_i) == dim_m - DIM_W'(1));

  mme_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (a_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  mme_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (b_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_in <= '0;
    end else begin
      mac_in.vld   <= rd_en;
      mac_in.first <= rd_en && (idx_t == '0);
    end
  end

  mme_mac #(
    .MAX_DIM (MAX_DIM)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_in),
    .a      (a_rd_data),
    .b      (b_rd_data),
    .busy   (mac_busy),
    .result (mac_result)
  );

  assign out_free = !out_valid || m_tready;

  always_comb begin
    out_load  = 1'b0;
    ld_row    = pend_row;
    ld_col    = pend_col;
    ld_value  = '0;
    ld_status = pend_status;
    ld_last   = 1'b1;
    unique case (state)
      ST_WEMIT: begin
        out_load = out_free;
      end
      ST_DRAIN: begin
        out_load  = out_free && !mac_busy;
        ld_row    = POS_W'(idx_i);
        ld_col    = POS_W'(idx_j);
        ld_value  = mac_result;
        ld_status = 1'b0;
        ld_last   = last_i && last_j;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx_i <= '0;
      idx_j <= '0;
      idx_t <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            idx_i <= '0;
            idx_j <= '0;
            idx_t <= '0;
            state <= (in_req == REQ_COMPUTE) ? ST_ISSUE : ST_WEMIT;
          end
        end
        ST_WEMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          if (last_t) begin
            idx_t <= '0;
            state <= ST_DRAIN;
          end else begin
            idx_t <= idx_t + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            if (last_j) begin
              idx_j <= '0;
              idx_i <= idx_i + IDX_W'(1);
            end else begin
              idx_j <= idx_j + IDX_W'(1);
            end
            state <= (last_i && last_j) ? ST_IDLE : ST_ISSUE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      unique case (in_req) inside
        REQ_WRITE_A, REQ_WRITE_B: begin
          pend_row    <= in_row;
          pend_col    <= in_col;
          pend_status <= !in_range;
        end
        REQ_COMPUTE: begin
          pend_row    <= '0;
          pend_col    <= '0;
          pend_status <= 1'b0;
        end
        default: begin
          pend_row    <= '0;
          pend_col    <= '0;
          pend_status <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row    <= ld_row;
      out_col    <= ld_col;
      out_value  <= ld_value;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_value, out_col, out_row};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  `ASSERT_SAME(a_store_write_idle, clk, rst, a_wr_en || b_wr_en, state == ST_IDLE)
  `ASSERT_SAME(a_no_emit_in_flight, clk, rst, (state == ST_DRAIN) && mac_busy, !out_load)
  `ASSERT_NEXT(a_issue_feeds_mac, clk, rst, state == ST_ISSUE, mac_in.vld)

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks matrix_multiply_engine_top against a behavioural predictor of the
// element stores and the saturated product, beat by beat. Directed tasks hit
// value extremes, range checks, the undefined request, saturation and the
// clamping of the dimension registers. A random phase then streams write runs
// and compute requests under several dimension settings. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
module testbench
  import mme_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 125;
  localparam longint SUM_MAX  = 64'sd2147483647;
  localparam longint SUM_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [RESULT_W-1:0] value;
    logic                status;
    logic                last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_A_ROWS;
  logic [3:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // row[2:0], col[5:3], value[21:6], zero pad
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // out_row[2:0], out_col[5:3], product_value[37:6], pad
  logic [0:0]  m_tuser;        // status[0]
  logic        m_tlast;

  reply_t reply_queue[$];
  int fail_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  logic [DIM_W-1:0]   dim_rows = 4'd8;
  logic [DIM_W-1:0]   dim_inner = 4'd8;
  logic [DIM_W-1:0]   dim_cols = 4'd8;
  logic [VALUE_W-1:0] left_mat [64] = '{default: '0};
  logic [VALUE_W-1:0] right_mat [64] = '{default: '0};

  matrix_multiply_engine_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[matrix_multiply_engine_top] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned used_dim(logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return 32'(r);
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return DIM_W'($urandom_range(1, 4));
    if (r == 7) return 4'd8;
    if (r == 8) return 4'd0;
    return DIM_W'($urandom_range(9, 15));
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // apply one request to the store copy and queue the beats it produces
  task automatic predict_reply(logic [REQ_W-1:0] req, logic [POS_W-1:0] row,
                               logic [POS_W-1:0] col, logic [VALUE_W-1:0] value);
    int unsigned m, n, p, rlim, clim;
    longint acc;
    reply_t r;
    m = used_dim(dim_rows);
    n = used_dim(dim_inner);
    p = used_dim(dim_cols);
    case (req) inside
      REQ_WRITE_A, REQ_WRITE_B: begin
        rlim = (req == REQ_WRITE_A) ? m : n;
        clim = (req == REQ_WRITE_A) ? n : p;
        r.row = row;
        r.col = col;
        r.value = '0;
        r.last = 1'b1;
        r.status = !(row < rlim && col < clim);
        if (!r.status) begin
          if (req == REQ_WRITE_A) left_mat[{row, col}] = value;
          else right_mat[{row, col}] = value;
        end
        reply_queue.push_back(r);
      end
      REQ_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int t = 0; t < n; t++)
              acc += longint'($signed(left_mat[i * 8 + t])) *
                     longint'($signed(right_mat[t * 8 + j]));
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < SUM_MIN) acc = SUM_MIN;
            r.row = i[POS_W-1:0];
            r.col = j[POS_W-1:0];
            r.value = acc[RESULT_W-1:0];
            r.status = 1'b0;
            r.last = (i == m - 1) && (j == p - 1);
            reply_queue.push_back(r);
          end
        end
      end
      default: begin
        r = '{row: '0, col: '0, value: '0, status: 1'b1, last: 1'b1};
        reply_queue.push_back(r);
      end
    endcase
  endtask

  task automatic send_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] row,
                              logic [POS_W-1:0] col, logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, value, col, row};
    do @(posedge clk); while (!s_tready);
    predict_reply(req, row, col, value);
  endtask

  // drop valid and hold until every queued beat has arrived
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] inner,
                          logic [DIM_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_A_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= CFG_INNER_DIM;
    cfg_data  <= inner;
    @(posedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_rows  = rows;
    dim_inner = inner;
    dim_cols  = cols;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.row    = m_tdata[2:0];
      got.col    = m_tdata[5:3];
      got.value  = m_tdata[37:6];
      got.status = m_tuser[0];
      got.last   = m_tlast;
      if (reply_queue.size() == 0) begin
        $error("unexpected beat: out_row %0d out_col %0d", got.row, got.col);
        fail_count++;
      end else begin
        want = reply_queue.pop_front();
        if (got.row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, got.row);
          fail_count++;
        end
        if (got.col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, got.col);
          fail_count++;
        end
        if (got.value !== want.value) begin
          $error("product_value: expected %0d, got %0d",
                 $signed(want.value), $signed(got.value));
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_request(REQ_WRITE_A, 3'd0, 3'd0, 16'h7FFF);
    send_request(REQ_WRITE_A, 3'd7, 3'd7, 16'h8000);
    send_request(REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
    send_request(REQ_WRITE_B, 3'd7, 3'd7, 16'h7FFF);
    send_request(REQ_UNDEF, 3'd5, 3'd6, 16'hFFFF);
    send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    wait_idle();
  endtask

  task automatic test_range_checks();
    set_dims(4'd2, 4'd3, 4'd4);
    send_request(REQ_WRITE_A, 3'd2, 3'd0, 16'h0101);
    send_request(REQ_WRITE_A, 3'd0, 3'd3, 16'h0202);
    send_request(REQ_WRITE_B, 3'd3, 3'd0, 16'h0303);
    send_request(REQ_WRITE_B, 3'd0, 3'd4, 16'h0404);
    send_request(REQ_WRITE_A, 3'd1, 3'd2, 16'h1234);
    send_request(REQ_WRITE_B, 3'd2, 3'd3, 16'h8001);
    send_request(REQ_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_saturation();
    set_dims(4'd1, 4'd3, 4'd2);
    for (int t = 0; t < 3; t++) begin
      send_request(REQ_WRITE_A, 3'd0, t[POS_W-1:0], 16'h8000);
      send_request(REQ_WRITE_B, t[POS_W-1:0], 3'd0, 16'h8000);
      send_request(REQ_WRITE_B, t[POS_W-1:0], 3'd1, 16'h7FFF);
    end
    send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    wait_idle();
  endtask

  task automatic test_dim_clamp();
    set_dims(4'd0, 4'd15, 4'd9);
    send_request(REQ_WRITE_A, 3'd0, 3'd7, 16'h0180);
    send_request(REQ_WRITE_A, 3'd1, 3'd0, 16'h7F00);
    send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int sent;
    int unsigned burst, pick, m, n, p;
    logic [REQ_W-1:0]   req;
    logic [POS_W-1:0]   row, col;
    logic [VALUE_W-1:0] value;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_dims(random_dim(), random_dim(), random_dim());
      no_idle = ($urandom_range(0, 4) == 0);
      m = used_dim(dim_rows);
      n = used_dim(dim_inner);
      p = used_dim(dim_cols);
      burst = $urandom_range(3, 10);
      repeat (burst) begin
        pick  = $urandom_range(0, 99);
        value = random_value();
        row   = POS_W'($urandom_range(0, 7));
        col   = POS_W'($urandom_range(0, 7));
        req   = $urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A;
        if (pick < 70) begin
          row = POS_W'($urandom_range(0, ((req == REQ_WRITE_A) ? m : n) - 1));
          col = POS_W'($urandom_range(0, ((req == REQ_WRITE_A) ? n : p) - 1));
        end else if (pick >= 87) begin
          req = REQ_COMPUTE;
        end else if (pick >= 82) begin
          req = REQ_UNDEF;
        end
        send_request(req, row, col, value);
        sent++;
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
      send_request(REQ_COMPUTE, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
                   random_value());
      sent++;
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_range_checks();
    test_saturation();
    test_dim_clamp();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("[matrix_multiply_engine_top] OK");
    end else begin
      $display("[matrix_multiply_engine_top] ERROR");
    end
    $finish;
  end

endmodule
